// File: hw/rtl/text_console_char_writer_defines.svh
// assertion macros for the text console character writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TXCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TXCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/txcw_pkg.sv
// shared types and constants of the text console character writer
package txcw_pkg;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    REG_TEXT_ATTRIBUTE = 1'b0,
    REG_SCROLL_ENABLE  = 1'b1
  } cfg_reg_t;

  localparam int unsigned CELL_W = 16;
  localparam int unsigned CFG_W  = 8;

  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  localparam logic [7:0] ATTR_RESET   = 8'h0F;
  localparam logic       SCROLL_RESET = 1'b1;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_column;
  } in_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
    logic [15:0] line_count;
  } out_t;

  typedef struct packed {
    logic [7:0] text_attribute;
    logic       scroll_enable;
  } cfg_t;

endpackage

// File: hw/rtl/txcw_screen_ram.sv
// single-port screen cell memory, registered read
module txcw_screen_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [txcw_pkg::CELL_W-1:0] wdata,
  output logic [txcw_pkg::CELL_W-1:0] rdata
);
  import txcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hw/rtl/txcw_ctrl.sv
// op sequencer: cursor, line counter, ring row offset and screen memory accesses
module txcw_ctrl #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned ADDR_W  = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  txcw_pkg::in_t               in_data,
  input  txcw_pkg::cfg_t              cfg,
  output logic                        res_valid,
  input  logic                        res_ready,
  output txcw_pkg::out_t              res,
  output logic                        mem_we,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [txcw_pkg::CELL_W-1:0] mem_wdata,
  input  logic [txcw_pkg::CELL_W-1:0] mem_rdata
);
  import txcw_pkg::*;

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned CELLS = COLUMNS * ROWS;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_PUT_NEXT,
    S_LINE,
    S_SCROLL,
    S_LSPACE,
    S_READ,
    S_DONE
  } state_t;

  state_t            state;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;
  logic [ROW_W-1:0]  top_row;
  logic [15:0]       line_cnt;
  logic [ADDR_W-1:0] sweep;
  logic [1:0]        tab_left;
  logic              scr;
  in_t               item;
  logic [7:0]        put_char;

  logic [COL_W:0]    nx;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic              rd_ok;

  assign nx    = {1'b0, cx} + 1'b1;
  assign rd_ok = (32'(item.cell_row) < ROWS) && (32'(item.cell_column) < COLUMNS);

  // a tab puts spaces
  assign put_char = (item.char_code == CHAR_TAB) ? CHAR_SPACE : item.char_code;

  // logical row to physical row through the ring offset
  always_comb begin
    sel_row = cy;
    sel_col = cx;
    case (state)
      S_PUT_NEXT: sel_col = nx[COL_W-1:0];
      S_SCROLL: begin
        sel_row = ROW_W'(ROWS - 1);
        sel_col = sweep[COL_W-1:0];
      end
      S_LSPACE:   sel_col = '0;
      S_READ: begin
        sel_row = ROW_W'(item.cell_row);
        sel_col = COL_W'(item.cell_column);
      end
      default: ;
    endcase
    row_sum = {1'b0, sel_row} + {1'b0, top_row};
    if (row_sum >= (ROW_W+1)'(ROWS)) begin
      phys_row = ROW_W'(row_sum - (ROW_W+1)'(ROWS));
    end else begin
      phys_row = row_sum[ROW_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = {cfg.text_attribute, CHAR_SPACE};
    mem_addr  = ADDR_W'(32'(phys_row) * COLUMNS + 32'(sel_col));
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = sweep;
        mem_wdata = '0;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = {cfg.text_attribute, put_char};
      end
      S_PUT_NEXT: mem_we = (32'(nx) < COLUMNS);
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_LSPACE:   mem_we = 1'b1;
      S_READ:     mem_re = 1'b1;
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.cursor_column = 7'(cx);
    res.cursor_row    = 5'(cy);
    res.scrolled      = scr;
    res.line_count    = line_cnt;
    if (item.op == OP_READ && rd_ok) begin
      res.read_char = mem_rdata[7:0];
      res.read_attr = mem_rdata[15:8];
    end else begin
      res.read_char = '0;
      res.read_attr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cx       <= '0;
      cy       <= '0;
      top_row  <= '0;
      line_cnt <= '0;
      sweep    <= '0;
      tab_left <= '0;
      scr      <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        // tab_left is already zero whenever the sequencer is idle
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            scr  <= 1'b0;
            if (in_data.op == OP_READ) begin
              state <= S_READ;
            end else begin
              case (in_data.char_code)
                CHAR_TAB: begin
                  tab_left <= 2'd2;
                  state    <= S_PUT;
                end
                CHAR_BACKSPACE: begin
                  if (cx != '0) begin
                    cx <= cx - 1'b1;
                  end
                  state <= S_DONE;
                end
                CHAR_CR: begin
                  cx    <= '0;
                  state <= S_DONE;
                end
                CHAR_LF: begin
                  cx    <= '0;
                  state <= S_LINE;
                end
                default: state <= S_PUT;
              endcase
            end
          end
        end
        S_PUT: state <= S_PUT_NEXT;
        S_PUT_NEXT: begin
          if (32'(nx) < COLUMNS) begin
            cx <= nx[COL_W-1:0];
            if (tab_left != '0) begin
              tab_left <= tab_left - 1'b1;
              state    <= S_PUT;
            end else begin
              state <= S_DONE;
            end
          end else begin
            cx    <= '0;
            state <= S_LINE;
          end
        end
        S_LINE: begin
          line_cnt <= line_cnt + 1'b1;
          sweep    <= '0;
          if (cy == ROW_W'(ROWS - 1)) begin
            if (cfg.scroll_enable) begin
              scr     <= 1'b1;
              top_row <= (top_row == ROW_W'(ROWS - 1)) ? '0 : top_row + 1'b1;
              state   <= S_SCROLL;
            end else begin
              state <= S_LSPACE;
            end
          end else begin
            cy    <= cy + 1'b1;
            state <= S_LSPACE;
          end
        end
        S_SCROLL: begin
          sweep <= sweep + 1'b1;
          if (sweep[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
            state <= S_LSPACE;
          end
        end
        S_LSPACE: begin
          if (tab_left != '0) begin
            tab_left <= tab_left - 1'b1;
            state    <= S_PUT;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/text_console_char_writer.sv
// text console character writer: 80x25 cell screen with cursor, put and read ops
// a tab is three spaces; each line advance that scrolls also clears the new bottom row
// throughput: one op at a time, the next accepted once the result is in the output register
// reset: synchronous; a clearing pass writes all ROWS*COLUMNS cells with in_ready low,
//   config writes are taken meanwhile
module text_console_char_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  txcw_pkg::in_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output txcw_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  txcw_pkg::cfg_reg_t       cfg_index,
  input  logic [txcw_pkg::CFG_W-1:0] cfg_data
);
  import txcw_pkg::*;

  `include "text_console_char_writer_defines.svh"

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // configuration registers; the user must write them only while no op is in flight (not enforced here)
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute <= ATTR_RESET;
      cfg.scroll_enable  <= SCROLL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_ATTRIBUTE: cfg.text_attribute <= cfg_data;
        REG_SCROLL_ENABLE:  cfg.scroll_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer to screen memory
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  // finished op result, handed to the output register
  logic res_valid;
  logic res_ready;
  out_t res;

  txcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // one port serves all accesses; reads and writes never fall in the same cycle
  txcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // output register: frees the sequencer so it can take the next transaction
  // while this result waits for the consumer
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  // one op in flight: an accepted transaction drops in_ready
  `TXCW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second op taken while busy")
  // cursor reported inside the screen
  `TXCW_ASSERT_NOW(a_col_on_screen, out_valid, 32'(out_data.cursor_column) < COLUMNS, "cursor column off screen")
  `TXCW_ASSERT_NOW(a_row_on_screen, out_valid && ROWS <= 32, 32'(out_data.cursor_row) < ROWS, "cursor row off screen")

endmodule

// File: test/text_console_char_writer_test.sv
// testbench of the text console character writer: directed table, then random put/read bursts
module text_console_char_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import txcw_pkg::*;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELLS          = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CLOCK_PERIOD   = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int ITEM_TARGET    = 1450;
  localparam int RANDOM_PHASES  = 5;
  localparam int LONG_IDLE      = 40;
  localparam int SETTLE_CYCLES  = 40;
  // worst op: a tab whose three spaces each wrap and scroll, with room to spare
  localparam int SLOWEST_OP     = 3 * (2 * CELLS + 16);
  localparam int CYCLE_LIMIT    =
    3 * ((ITEM_TARGET + 50) * (SLOWEST_OP + 2 * LONG_IDLE) + CELLS + 1000);

  // one row of the directed table: the transaction and, where obvious, its result
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t result;
  } probe_row_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  in_t             in_data;
  logic            out_valid;
  logic            out_ready;
  out_t            out_data;
  logic            cfg_we;
  cfg_reg_t        cfg_index;
  logic [CFG_W-1:0] cfg_data;

  text_console_char_writer #(
    .COLUMNS(SCREEN_COLUMNS),
    .ROWS   (SCREEN_ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // screen contents and cursor as the console should hold them
  logic [15:0] screen_image [CELLS];
  int          cur_col;
  int          cur_row;
  logic [15:0] lines_advanced;
  logic [7:0]  attr_now;
  logic        scroll_now;

  out_t        pending_results [$];
  probe_row_t  script [$];
  int          items_sent;
  int          mismatches;
  int          cycle_count;
  int          ready_hold;
  bit          calm;

  always #(CLOCK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // console predictor
  // ---------------------------------------------------------------------------

  // write a character with the current attribute, dropped when off the screen
  function automatic void paint(int col, int row, logic [7:0] ch);
    if (col < SCREEN_COLUMNS && row < SCREEN_ROWS)
      screen_image[row * SCREEN_COLUMNS + col] = {attr_now, ch};
  endfunction

  // move down one line; at the bottom either scroll or just stay put
  function automatic bit next_line();
    bit rolled;
    int i;
    rolled = 1'b0;
    cur_row++;
    lines_advanced++;
    if (cur_row >= SCREEN_ROWS) begin
      cur_row = SCREEN_ROWS - 1;
      if (scroll_now) begin
        for (i = 0; i < CELLS - SCREEN_COLUMNS; i++)
          screen_image[i] = screen_image[i + SCREEN_COLUMNS];
        for (i = CELLS - SCREEN_COLUMNS; i < CELLS; i++)
          screen_image[i] = 16'h0000;
        rolled = 1'b1;
      end
    end
    // fresh line gets a blank at the cursor
    paint(cur_col, cur_row, CHAR_SPACE);
    return rolled;
  endfunction

  // every byte except tab
  function automatic bit place_byte(logic [7:0] ch);
    bit rolled;
    rolled = 1'b0;
    if (ch == CHAR_BACKSPACE) begin
      if (cur_col > 0)
        cur_col--;
    end else if (ch == CHAR_CR) begin
      cur_col = 0;
    end else if (ch == CHAR_LF) begin
      cur_col = 0;
      rolled = next_line();
    end else begin
      paint(cur_col, cur_row, ch);
      cur_col++;
      paint(cur_col, cur_row, CHAR_SPACE);
    end
    // ran off the right edge: wrap to the next line
    if (cur_col > SCREEN_COLUMNS - 1) begin
      cur_col = 0;
      if (next_line())
        rolled = 1'b1;
    end
    return rolled;
  endfunction

  function automatic out_t console_step(in_t item);
    out_t        res;
    logic [15:0] cell_word;
    int          k;
    res = '0;
    if (item.op == OP_PUT) begin
      if (item.char_code == CHAR_TAB) begin
        // a tab is three spaces, any of which may wrap or scroll
        for (k = 0; k < 3; k++)
          if (place_byte(CHAR_SPACE))
            res.scrolled = 1'b1;
      end else begin
        res.scrolled = place_byte(item.char_code);
      end
    end else if (item.cell_row < SCREEN_ROWS && item.cell_column < SCREEN_COLUMNS) begin
      cell_word = screen_image[int'(item.cell_row) * SCREEN_COLUMNS + int'(item.cell_column)];
      res.read_char = cell_word[7:0];
      res.read_attr = cell_word[15:8];
    end
    res.cursor_column = 7'(cur_col);
    res.cursor_row    = 5'(cur_row);
    res.line_count    = lines_advanced;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result %0h with no transaction pending", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.cursor_column !== want.cursor_column)
      report_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
    if (got.cursor_row !== want.cursor_row)
      report_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
    if (got.read_char !== want.read_char)
      report_field("read_char", 16'(want.read_char), 16'(got.read_char));
    if (got.read_attr !== want.read_attr)
      report_field("read_attr", 16'(want.read_attr), 16'(got.read_attr));
    if (got.scrolled !== want.scrolled)
      report_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
    if (got.line_count !== want.line_count)
      report_field("line_count", want.line_count, got.line_count);
  endtask

  // output side: values seen here are the ones just before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      check_result(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, now and then a long one
  function automatic int idle_len();
    int pick;
    if (calm)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, LONG_IDLE);
  endfunction

  // receiver stalls: hold ready for a while, then maybe drop it for a while
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ready && !calm) begin
      ready_hold = idle_len();
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end
    end else begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 12);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // entered at a falling edge, returns at the falling edge after the transaction
  task automatic send_op(in_t item, logic typed, out_t typed_result);
    int   gap;
    out_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = console_step(item);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_op(logic [7:0] ch);
    in_t item;
    item.op          = OP_PUT;
    item.char_code   = ch;
    item.cell_row    = 5'($urandom);
    item.cell_column = 7'($urandom);
    send_op(item, 1'b0, '0);
  endtask

  // both registers back to back, only called while no op is in flight
  task automatic set_config(logic [7:0] attr, logic scroll);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEXT_ATTRIBUTE;
    cfg_data  <= attr;
    @(negedge clk);
    cfg_index <= REG_SCROLL_ENABLE;
    cfg_data  <= {7'd0, scroll};
    @(negedge clk);
    cfg_we     <= 1'b0;
    attr_now   = attr;
    scroll_now = scroll;
  endtask

  // drain everything in flight, then a few quiet cycles
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_probe(op_t op, logic [7:0] ch, logic [4:0] row,
                                    logic [6:0] col, logic typed, out_t result);
    probe_row_t entry;
    entry.item.op          = op;
    entry.item.char_code   = ch;
    entry.item.cell_row    = row;
    entry.item.cell_column = col;
    entry.typed            = typed;
    entry.result           = result;
    script.push_back(entry);
  endfunction

  // mostly plain ascii, sometimes any byte but tab, backspace, cr and lf
  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    if ($urandom_range(0, 99) < 85)
      return 8'($urandom_range(8'h20, 8'h7E));
    ch = 8'($urandom);
    while (ch == CHAR_TAB || ch == CHAR_BACKSPACE || ch == CHAR_CR || ch == CHAR_LF)
      ch = 8'($urandom);
    return ch;
  endfunction

  task automatic read_burst();
    int  n;
    int  back;
    in_t item;
    n = $urandom_range(1, 6);
    repeat (n) begin
      item.op        = OP_READ;
      item.char_code = 8'($urandom);
      if ($urandom_range(0, 6) == 0) begin
        // off the screen in one coordinate or the other
        item.cell_row    = 5'($urandom);
        item.cell_column = 7'($urandom);
        if ($urandom_range(0, 1) == 1)
          item.cell_row = 5'($urandom_range(SCREEN_ROWS, 31));
        else
          item.cell_column = 7'($urandom_range(SCREEN_COLUMNS, 127));
      end else begin
        // mostly near the cursor where the text is fresh
        back = $urandom_range(0, 2);
        if ($urandom_range(0, 2) != 0 && cur_row >= back)
          item.cell_row = 5'(cur_row - back);
        else
          item.cell_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        item.cell_column = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
      end
      send_op(item, 1'b0, '0);
    end
  endtask

  task automatic random_burst();
    int  kind;
    int  len;
    in_t item;
    calm = ($urandom_range(0, 7) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // a line of text, now and then long enough to wrap
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 30);
      repeat (len) put_op(text_char());
      len = $urandom_range(0, 99);
      if (len < 15)
        put_op(CHAR_CR);
      if (len < 65)
        put_op(CHAR_LF);
    end else if (kind < 65) begin
      read_burst();
    end else if (kind < 80) begin
      // control characters mixed with the odd printable
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 4))
          0:       put_op(CHAR_BACKSPACE);
          1:       put_op(CHAR_CR);
          2:       put_op(CHAR_TAB);
          3:       put_op(CHAR_LF);
          default: put_op(text_char());
        endcase
      end
    end else if (kind < 90) begin
      // anything at all
      repeat ($urandom_range(1, 5)) begin
        item.op          = op_t'($urandom_range(0, 1));
        item.char_code   = 8'($urandom);
        item.cell_row    = 5'($urandom);
        item.cell_column = 7'($urandom);
        send_op(item, 1'b0, '0);
      end
    end else begin
      // run of line feeds to push the bottom row and scrolling hard
      repeat ($urandom_range(1, 8)) put_op(CHAR_LF);
    end
  endtask

  initial begin
    int         phase;
    int         phase_end;
    int         i;
    probe_row_t entry;

    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_TEXT_ATTRIBUTE;
    cfg_data   = '0;
    ready_hold = 0;
    calm       = 1'b0;
    items_sent = 0;
    mismatches = 0;
    cycle_count = 0;

    // predictor starts from the cleared screen and reset registers
    for (i = 0; i < CELLS; i++)
      screen_image[i] = 16'h0000;
    cur_col        = 0;
    cur_row        = 0;
    lines_advanced = 16'd0;
    attr_now       = ATTR_RESET;
    scroll_now     = SCROLL_RESET;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // registers are taken during the clearing pass too
    set_config(8'h1E, 1'b1);

    // directed table: reads of the cleared screen, byte extremes, every control
    add_probe(OP_READ, 8'hFF, 5'd0,  7'd0,   1'b1, '0);
    add_probe(OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '0);
    add_probe(OP_READ, 8'h00, 5'd24, 7'd79,  1'b1, '0);
    add_probe(OP_PUT,  8'h41, 5'd31, 7'd127, 1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd0,  7'd0,   1'b1,
              out_t'{7'd1, 5'd0, 8'h41, 8'h1E, 1'b0, 16'd0});
    // the trailing blank after a printable byte
    add_probe(OP_READ, 8'h00, 5'd0,  7'd1,   1'b1,
              out_t'{7'd1, 5'd0, CHAR_SPACE, 8'h1E, 1'b0, 16'd0});
    add_probe(OP_PUT,  CHAR_BACKSPACE, 5'd0, 7'd0, 1'b0, '0);
    // backspace already at column 0 stays there
    add_probe(OP_PUT,  CHAR_BACKSPACE, 5'd0, 7'd0, 1'b1, '0);
    add_probe(OP_PUT,  8'h00, 5'd0,  7'd0,   1'b0, '0);
    add_probe(OP_PUT,  8'hFF, 5'd31, 7'd0,   1'b0, '0);
    add_probe(OP_PUT,  8'h7F, 5'd0,  7'd127, 1'b0, '0);
    add_probe(OP_PUT,  8'h80, 5'd0,  7'd0,   1'b0, '0);
    add_probe(OP_PUT,  CHAR_TAB, 5'd0, 7'd0, 1'b0, '0);
    add_probe(OP_PUT,  CHAR_CR,  5'd0, 7'd0, 1'b1, '0);
    add_probe(OP_READ, 8'h00, 5'd0,  7'd1,   1'b0, '0);
    add_probe(OP_PUT,  CHAR_LF,  5'd0, 7'd0, 1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd1,  7'd0,   1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd0,  7'd80,  1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd25, 7'd0,   1'b0, '0);
    add_probe(OP_PUT,  8'h5A, 5'd0,  7'd0,   1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd0,  7'd3,   1'b0, '0);
    add_probe(OP_PUT,  CHAR_LF,  5'd0, 7'd0, 1'b0, '0);
    add_probe(OP_READ, 8'h00, 5'd2,  7'd0,   1'b0, '0);

    foreach (script[i]) begin
      entry = script[i];
      send_op(entry.item, entry.typed, entry.result);
    end
    settle_idle();

    // random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_config(8'h00, 1'b0);
        1:       set_config(8'hFF, 1'b1);
        2:       set_config(8'($urandom), 1'b0);
        3:       set_config(8'($urandom), 1'b1);
        default: set_config(ATTR_RESET, SCROLL_RESET);
      endcase
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - phase);
      while (items_sent < phase_end)
        random_burst();
      settle_idle();
    end

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
